>>> rtl/bls_pkg.sv
// Package for the ballistic launch solver: register codes, reset values,
// field widths and the saturation helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bls_pkg;

  localparam int COORD_W = 32;
  localparam int SPEED_W = 31;
  localparam int TIME_W  = 31;
  localparam int QUOT_W  = 32;

  localparam logic [SPEED_W-1:0] SPEED_RESET   = 31'd6553600;
  localparam logic [COORD_W-1:0] GRAVITY_RESET = 32'hFFF6_3333;

  typedef enum logic [0:0] {
    REG_MUZZLE_SPEED = 1'b0,
    REG_GRAVITY      = 1'b1
  } reg_index_t;

  // Signed saturation of a magnitude quotient; ovf means the quotient is >= 2^32.
  function automatic logic [COORD_W-1:0] sat_vel(input logic [QUOT_W-1:0] q,
                                                 input logic ovf, input logic neg);
    logic big;
    big = ovf || q[QUOT_W-1];
    if (neg) begin
      sat_vel = big ? 32'h8000_0000 : (32'd0 - q);
    end else begin
      sat_vel = big ? 32'h7FFF_FFFF : q;
    end
  endfunction

  function automatic logic [TIME_W-1:0] sat_time(input logic [QUOT_W-1:0] q,
                                                 input logic ovf);
    sat_time = (ovf || q[QUOT_W-1]) ? 31'h7FFF_FFFF : q[TIME_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/bls_if.sv
// Valid/ready channel interfaces for the solver's aim items and results.
// Depends on bls_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bls_in_if;
  logic valid;
  logic ready;
  logic signed [bls_pkg::COORD_W-1:0] cannon_x;
  logic signed [bls_pkg::COORD_W-1:0] cannon_y;
  logic signed [bls_pkg::COORD_W-1:0] cannon_z;
  logic signed [bls_pkg::COORD_W-1:0] target_x;
  logic signed [bls_pkg::COORD_W-1:0] target_y;
  logic signed [bls_pkg::COORD_W-1:0] target_z;
  logic high_arc;

  modport source (output valid, cannon_x, cannon_y, cannon_z, target_x, target_y,
                  target_z, high_arc, input ready);
  modport sink (input valid, cannon_x, cannon_y, cannon_z, target_x, target_y,
                target_z, high_arc, output ready);
endinterface

interface bls_out_if;
  logic valid;
  logic ready;
  logic in_range;
  logic signed [bls_pkg::COORD_W-1:0] launch_vx;
  logic signed [bls_pkg::COORD_W-1:0] launch_vy;
  logic signed [bls_pkg::COORD_W-1:0] launch_vz;
  logic [bls_pkg::TIME_W-1:0] flight_time;

  modport source (output valid, in_range, launch_vx, launch_vy, launch_vz, flight_time,
                  input ready);
  modport sink (input valid, in_range, launch_vx, launch_vy, launch_vz, flight_time,
                output ready);
endinterface

`default_nettype wire

>>> rtl/bls_mul.sv
// Two-stage unsigned multiplier built from 32x32 limb products.
// Stage 1 registers the limb products, stage 2 registers their sum.
`timescale 1ns / 1ps
`default_nettype none

module bls_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  localparam int NA   = (AW + 31) / 32;
  localparam int NB   = (BW + 31) / 32;
  localparam int SUMW = 32 * (NA + NB);

  logic [32*NA-1:0] ax;
  logic [32*NB-1:0] bx;
  logic [63:0]      pp [NA*NB];
  logic [SUMW-1:0]  sum;

  assign ax = (32*NA)'(a);
  assign bx = (32*NB)'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i*NB+j] <= 64'(ax[32*i +: 32]) * 64'(bx[32*j +: 32]);
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum = sum + (SUMW'(pp[i*NB+j]) << (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= sum[AW+BW-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/bls_sqrt.sv
// Pipelined integer square root, one result bit per stage (W/2 stages).
// Restoring digit-by-digit method; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bls_sqrt #(
  parameter int W = 128
) (
  input  logic             clk,
  input  logic             en,
  input  logic [W-1:0]     x,
  output logic [W/2-1:0]   root
);

  localparam int RW = W / 2;

  logic [RW+1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [W-1:0]  x_q    [RW];

  for (genvar k = 0; k < RW; k++) begin : g_st
    logic [RW+1:0] prem;
    logic [RW-1:0] proot;
    logic [W-1:0]  px;
    logic [RW+3:0] cur;
    logic [RW+3:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign prem  = '0;
      assign proot = '0;
      assign px    = x;
    end else begin : g_next
      assign prem  = rem_q[k-1];
      assign proot = root_q[k-1];
      assign px    = x_q[k-1];
    end

    assign cur   = {prem, px[W-1:W-2]};
    assign trial = (RW+4)'({proot, 2'b01});
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? (RW+2)'(cur - trial) : (RW+2)'(cur);
        root_q[k] <= {proot[RW-2:0], ge};
        x_q[k]    <= px << 2;
      end
    end
  end

  assign root = root_q[RW-1];

endmodule

`default_nettype wire

>>> rtl/bls_div.sv
// Pipelined restoring divider: QW quotient bits, one per stage, plus an
// entry stage that flags quotients of 2^QW or more. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bls_div #(
  parameter int DW = 64,
  parameter int QW = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DW+QW-1:0] n,
  input  logic [DW-1:0]    d,
  output logic [QW-1:0]    q,
  output logic             ovf
);

  logic [DW-1:0] rem0;
  logic [QW-1:0] lo0;
  logic [DW-1:0] d0;
  logic          ovf0;

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] lo_q  [QW];
  logic [QW-1:0] quo_q [QW];
  logic [DW-1:0] d_q   [QW];
  logic          ovf_q [QW];

  always_ff @(posedge clk) begin
    if (en) begin
      rem0 <= n[DW+QW-1:QW];
      lo0  <= n[QW-1:0];
      d0   <= d;
      ovf0 <= n[DW+QW-1:QW] >= d;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic [DW-1:0] prem;
    logic [QW-1:0] plo;
    logic [QW-1:0] pquo;
    logic [DW-1:0] pd;
    logic          povf;
    logic [DW:0]   cur;
    logic          ge;

    if (k == 0) begin : g_first
      assign prem = rem0;
      assign plo  = lo0;
      assign pquo = '0;
      assign pd   = d0;
      assign povf = ovf0;
    end else begin : g_next
      assign prem = rem_q[k-1];
      assign plo  = lo_q[k-1];
      assign pquo = quo_q[k-1];
      assign pd   = d_q[k-1];
      assign povf = ovf_q[k-1];
    end

    assign cur = {prem, plo[QW-1]};
    assign ge  = cur >= {1'b0, pd};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? DW'(cur - {1'b0, pd}) : DW'(cur);
        lo_q[k]  <= plo << 1;
        quo_q[k] <= {pquo[QW-2:0], ge};
        d_q[k]   <= pd;
        ovf_q[k] <= povf;
      end
    end
  end

  assign q   = quo_q[QW-1];
  assign ovf = ovf_q[QW-1];

endmodule

`default_nettype wire

>>> rtl/bls_dly.sv
// Delay line for an item's valid bit and side data, matched to the latency
// of the arithmetic units it runs beside. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bls_dly #(
  parameter int W = 8,
  parameter int L = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  logic [W-1:0] d,
  output logic         out_valid,
  output logic [W-1:0] q
);

  logic         v [L];
  logic [W-1:0] s [L];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < L; k++) begin
        v[k] <= 1'b0;
      end
    end else if (en) begin
      v[0] <= in_valid;
      for (int k = 1; k < L; k++) begin
        v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s[0] <= d;
      for (int k = 1; k < L; k++) begin
        s[k] <= s[k-1];
      end
    end
  end

  assign out_valid = v[L-1];
  assign q         = s[L-1];

endmodule

`default_nettype wire

>>> rtl/ballistic_launch_solver.sv
// Ballistic launch solver top level; throughput one item per cycle while the
// output is not stalled. Two 64-stage square roots and the 33-stage dividers
// set the depth. A stalled output freezes the whole pipe.
// Synchronous reset clears valid bits and restores the speed and gravity regs.
// Uses bls_pkg, bls_if, bls_mul, bls_sqrt, bls_div and bls_dly.
`timescale 1ns / 1ps
`default_nettype none

module ballistic_launch_solver (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  bls_pkg::reg_index_t wr_index,
  input  logic [31:0]         wr_data,
  bls_in_if.sink              in,
  bls_out_if.source           out
);

  typedef struct packed {
    logic          ok;
    logic          gneg;
    logic          hneg;
    logic          high;
    logic          nneg;
    logic          dxn;
    logic          dzn;
    logic [32:0]   adx;
    logic [32:0]   adz;
    logic [61:0]   a2;
    logic [61:0]   avg;
    logic [127:0]  gr;
  } ctx_t;

  typedef struct packed {
    logic          ok;
    logic          syn;
    logic          dxn;
    logic          dzn;
    logic [94:0]   nvx;
    logic [94:0]   nvy;
    logic [94:0]   nvz;
    logic [61:0]   avg;
  } tail_t;

  typedef struct packed {
    logic ok;
    logic syn;
    logic dxn;
    logic dzn;
  } flag_t;

  logic [bls_pkg::SPEED_W-1:0]        muzzle_speed;
  logic signed [bls_pkg::COORD_W-1:0] gravity;
  logic en;

  always_ff @(posedge clk) begin
    if (rst) begin
      muzzle_speed <= bls_pkg::SPEED_RESET;
      gravity      <= bls_pkg::GRAVITY_RESET;
    end else if (wr_en) begin
      case (wr_index)
        bls_pkg::REG_MUZZLE_SPEED: muzzle_speed <= wr_data[bls_pkg::SPEED_W-1:0];
        bls_pkg::REG_GRAVITY:      gravity      <= wr_data;
        default: ;
      endcase
    end
  end

  assign en       = !out.valid || out.ready;
  assign in.ready = en;

  // Stage A: differences, magnitudes and degenerate-case flags
  logic signed [32:0] dx_c, h_c, dz_c, gs_c;
  logic va;
  ctx_t ctx_a;
  logic [32:0] ah_a;
  logic [31:0] gm_a;

  assign dx_c = 33'(in.target_x) - 33'(in.cannon_x);
  assign h_c  = 33'(in.target_y) - 33'(in.cannon_y);
  assign dz_c = 33'(in.target_z) - 33'(in.cannon_z);
  assign gs_c = -33'(gravity);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_a.ok   <= !(muzzle_speed == '0 || gravity == '0 || (dx_c == '0 && dz_c == '0));
      ctx_a.gneg <= gs_c[32];
      ctx_a.hneg <= h_c[32];
      ctx_a.high <= in.high_arc;
      ctx_a.nneg <= 1'b0;
      ctx_a.dxn  <= dx_c[32];
      ctx_a.dzn  <= dz_c[32];
      ctx_a.adx  <= dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
      ctx_a.adz  <= dz_c[32] ? 33'(-dz_c) : 33'(dz_c);
      ctx_a.a2   <= '0;
      ctx_a.avg  <= '0;
      ctx_a.gr   <= '0;
      ah_a       <= h_c[32] ? 33'(-h_c) : 33'(h_c);
      gm_a       <= gs_c[32] ? 32'(-gs_c) : 32'(gs_c);
    end
  end

  // M1: squares and simple products
  logic [65:0] p_adx2, p_adz2;
  logic [63:0] p_gm2;
  logic [64:0] p_gmh;
  logic [61:0] p_a2;
  logic [62:0] p_avg;
  logic v1;
  ctx_t ctx1;

  bls_mul #(.AW(33), .BW(33)) u_adx2 (.clk, .en, .a(ctx_a.adx), .b(ctx_a.adx), .p(p_adx2));
  bls_mul #(.AW(33), .BW(33)) u_adz2 (.clk, .en, .a(ctx_a.adz), .b(ctx_a.adz), .p(p_adz2));
  bls_mul #(.AW(32), .BW(32)) u_gm2  (.clk, .en, .a(gm_a), .b(gm_a), .p(p_gm2));
  bls_mul #(.AW(32), .BW(33)) u_gmh  (.clk, .en, .a(gm_a), .b(ah_a), .p(p_gmh));
  bls_mul #(.AW(31), .BW(31)) u_a2   (.clk, .en, .a(muzzle_speed), .b(muzzle_speed),
                                      .p(p_a2));
  bls_mul #(.AW(31), .BW(32)) u_avg  (.clk, .en, .a(muzzle_speed), .b(gm_a), .p(p_avg));
  bls_dly #(.W($bits(ctx_t)), .L(2)) u_d1 (.clk, .rst, .en, .in_valid(va), .d(ctx_a),
                                           .out_valid(v1), .q(ctx1));

  // Stage B: R^2
  logic vb;
  ctx_t ctx_b;
  logic [65:0] r2_b;
  logic [62:0] gm2_b;
  logic [63:0] gmh_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_b     <= ctx1;
      ctx_b.a2  <= p_a2;
      ctx_b.avg <= p_avg[61:0];
      r2_b      <= p_adx2 + p_adz2;
      gm2_b     <= p_gm2[62:0];
      gmh_b     <= p_gmh[63:0];
    end
  end

  // M2: g^2 R^2, g h a^2, a^4
  logic [128:0] p_gr;
  logic [125:0] p_t;
  logic [123:0] p_a4;
  logic v2;
  ctx_t ctx2;

  bls_mul #(.AW(66), .BW(63)) u_gr (.clk, .en, .a(r2_b), .b(gm2_b), .p(p_gr));
  bls_mul #(.AW(64), .BW(62)) u_t  (.clk, .en, .a(gmh_b), .b(ctx_b.a2), .p(p_t));
  bls_mul #(.AW(62), .BW(62)) u_a4 (.clk, .en, .a(ctx_b.a2), .b(ctx_b.a2), .p(p_a4));
  bls_dly #(.W($bits(ctx_t)), .L(2)) u_d2 (.clk, .rst, .en, .in_valid(vb), .d(ctx_b),
                                           .out_valid(v2), .q(ctx2));

  // Stage C: sort the terms of the discriminant by sign
  logic [127:0] t2_c, a4_c, gr_c;
  logic vc;
  ctx_t ctx_c;
  logic [127:0] pos_c, neg_c;

  assign t2_c = 128'(p_t) << 1;
  assign a4_c = 128'(p_a4);
  assign gr_c = p_gr[127:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_c    <= ctx2;
      ctx_c.gr <= gr_c;
      if (ctx2.gneg != ctx2.hneg) begin
        pos_c <= a4_c + t2_c;
        neg_c <= gr_c;
      end else begin
        pos_c <= a4_c;
        neg_c <= gr_c + t2_c;
      end
    end
  end

  // Stage D: discriminant and range test
  logic vd;
  ctx_t ctx_d;
  logic [127:0] diff_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_d    <= ctx_c;
      ctx_d.ok <= ctx_c.ok && (pos_c >= neg_c);
      diff_d   <= pos_c - neg_c;
    end
  end

  // SQ1: s = sqrt(discriminant)
  logic [63:0] s_root;
  logic v3;
  ctx_t ctx3;

  bls_sqrt #(.W(128)) u_sq1 (.clk, .en, .x(diff_d), .root(s_root));
  bls_dly #(.W($bits(ctx_t)), .L(64)) u_d3 (.clk, .rst, .en, .in_valid(vd), .d(ctx_d),
                                            .out_valid(v3), .q(ctx3));

  // Stage E: pick the root
  logic ve;
  ctx_t ctx_e;
  logic [63:0] nm_e;
  logic [63:0] a2w;

  assign a2w = 64'(ctx3.a2);

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (en) begin
      ve <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_e <= ctx3;
      if (ctx3.high) begin
        nm_e       <= a2w + s_root;
        ctx_e.nneg <= 1'b0;
      end else if (a2w >= s_root) begin
        nm_e       <= a2w - s_root;
        ctx_e.nneg <= 1'b0;
      end else begin
        nm_e       <= s_root - a2w;
        ctx_e.nneg <= 1'b1;
      end
    end
  end

  // M3: N^2 and the velocity numerators
  logic [127:0] p_nm2;
  logic [94:0]  p_vx, p_vy, p_vz;
  logic v4;
  ctx_t ctx4;

  bls_mul #(.AW(64), .BW(64)) u_nm2 (.clk, .en, .a(nm_e), .b(nm_e), .p(p_nm2));
  bls_mul #(.AW(31), .BW(64)) u_vy  (.clk, .en, .a(muzzle_speed), .b(nm_e), .p(p_vy));
  bls_mul #(.AW(62), .BW(33)) u_vx  (.clk, .en, .a(ctx_e.avg), .b(ctx_e.adx), .p(p_vx));
  bls_mul #(.AW(62), .BW(33)) u_vz  (.clk, .en, .a(ctx_e.avg), .b(ctx_e.adz), .p(p_vz));
  bls_dly #(.W($bits(ctx_t)), .L(2)) u_d4 (.clk, .rst, .en, .in_valid(ve), .d(ctx_e),
                                           .out_valid(v4), .q(ctx4));

  // Stage F: q^2 = g^2 R^2 + N^2, wrapping at 128 bits
  logic vf;
  tail_t tail_f;
  logic [127:0] q2_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en) begin
      vf <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q2_f       <= ctx4.gr + p_nm2;
      tail_f.ok  <= ctx4.ok;
      tail_f.syn <= ctx4.nneg != ctx4.gneg;
      tail_f.dxn <= ctx4.dxn;
      tail_f.dzn <= ctx4.dzn;
      tail_f.nvx <= p_vx;
      tail_f.nvy <= p_vy;
      tail_f.nvz <= p_vz;
      tail_f.avg <= ctx4.avg;
    end
  end

  // SQ2: q = sqrt(q^2)
  logic [63:0] qn;
  logic v5;
  tail_t tail5;

  bls_sqrt #(.W(128)) u_sq2 (.clk, .en, .x(q2_f), .root(qn));
  bls_dly #(.W($bits(tail_t)), .L(64)) u_d5 (.clk, .rst, .en, .in_valid(vf), .d(tail_f),
                                             .out_valid(v5), .q(tail5));

  // Dividers; zero divisors only occur on items that report out of range
  logic [63:0] dq, dt;
  flag_t flag5, flag6;
  logic v6;
  logic [31:0] qx, qy, qz, qt;
  logic ox, oy, oz, ot;

  assign dq = (qn == '0) ? 64'd1 : qn;
  assign dt = (tail5.avg == '0) ? 64'd1 : 64'(tail5.avg);

  assign flag5.ok  = tail5.ok && (qn != '0);
  assign flag5.syn = tail5.syn;
  assign flag5.dxn = tail5.dxn;
  assign flag5.dzn = tail5.dzn;

  bls_div #(.DW(64), .QW(bls_pkg::QUOT_W)) u_dvx (.clk, .en, .n(96'(tail5.nvx)), .d(dq),
                                                 .q(qx), .ovf(ox));
  bls_div #(.DW(64), .QW(bls_pkg::QUOT_W)) u_dvy (.clk, .en, .n(96'(tail5.nvy)), .d(dq),
                                                 .q(qy), .ovf(oy));
  bls_div #(.DW(64), .QW(bls_pkg::QUOT_W)) u_dvz (.clk, .en, .n(96'(tail5.nvz)), .d(dq),
                                                 .q(qz), .ovf(oz));
  bls_div #(.DW(64), .QW(bls_pkg::QUOT_W)) u_dft (.clk, .en, .n({16'd0, qn, 16'd0}),
                                                 .d(dt), .q(qt), .ovf(ot));
  bls_dly #(.W($bits(flag_t)), .L(bls_pkg::QUOT_W + 1)) u_d6 (.clk, .rst, .en,
                                                              .in_valid(v5), .d(flag5),
                                                              .out_valid(v6), .q(flag6));

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (en) begin
      out.valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out.in_range <= flag6.ok;
      if (flag6.ok) begin
        out.launch_vx   <= bls_pkg::sat_vel(qx, ox, flag6.dxn);
        out.launch_vy   <= bls_pkg::sat_vel(qy, oy, flag6.syn);
        out.launch_vz   <= bls_pkg::sat_vel(qz, oz, flag6.dzn);
        out.flight_time <= bls_pkg::sat_time(qt, ot);
      end else begin
        out.launch_vx   <= '0;
        out.launch_vy   <= '0;
        out.launch_vz   <= '0;
        out.flight_time <= '0;
      end
    end
  end

endmodule

`default_nettype wire
